// ===== hdl/bfi_pkg.sv =====
// Shared types and constants for the Bloom filter bitmap insert core.
// No dependencies; imported by every module of the block but bfi_ram.
`timescale 1ns / 1ps
`default_nettype none

package bfi_pkg;

  localparam int MAX_SIZE_LOG   = 18;
  localparam int WORD_W         = 32;
  localparam int BIT_W          = $clog2(WORD_W);          // bit position in a word
  localparam int WORD_AW        = MAX_SIZE_LOG - BIT_W;    // bitmap word address
  localparam int WORD_COUNT     = 1 << WORD_AW;
  localparam int IDX_W          = MAX_SIZE_LOG;            // masked probe index
  localparam int NUM_PROBES_MAX = 8;
  localparam int PROBE_CW       = $clog2(NUM_PROBES_MAX);
  localparam int HASH_W         = 32;
  localparam int ROT_AMT        = 16;
  localparam int SIZE_LOG_W     = 5;
  localparam int NUM_PROBES_W   = 4;
  localparam int SIZE_LOG_MIN   = 5;
  localparam int WIDX_W         = 13;                      // word_index field width
  localparam int Q_DEPTH        = 2;
  localparam int Q_AW           = $clog2(Q_DEPTH);
  localparam int IN_TDATA_W     = 144;                     // 4 x 32 + 13, padded to bytes
  localparam int CFG_AW         = 3;

  // kind field codes
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_INSERT = 2'd0;
  localparam kind_t KIND_READ   = 2'd1;
  localparam kind_t KIND_CLEAR  = 2'd2;

  // register indexes (paddr[2])
  localparam logic REG_SIZE_LOG   = 1'b0;
  localparam logic REG_NUM_PROBES = 1'b1;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INSERT,
    ST_READ
  } back_state_t;

  // one classified transaction waiting for the back end
  typedef struct packed {
    op_t                                     op;
    logic [PROBE_CW-1:0]                     last_probe;
    logic [NUM_PROBES_MAX-1:0][IDX_W-1:0]    idx;
    logic [WORD_AW-1:0]                      word_index;
    logic                                    rd_zero;
  } entry_t;

endpackage

`default_nettype wire

// ===== hdl/bfi_ram.sv =====
// Generic single-write, single-read RAM with registered read data (read-first).
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bfi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bfi_front.sv =====
// Front end: accepts input transactions and turns them into queue entries
// (masked probe indices, probe count, read range check). Uses bfi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfi_front
  import bfi_pkg::*;
(
  input  wire logic                    in_tvalid,
  output      logic                    in_tready,
  input  wire logic [IN_TDATA_W-1:0]   in_tdata,
  input  wire kind_t                   in_tuser,
  input  wire logic [SIZE_LOG_W-1:0]   size_log,
  input  wire logic [NUM_PROBES_W-1:0] num_probes,
  input  wire logic                    init_busy,
  input  wire logic                    push_ready,
  output      logic                    push_valid,
  output      entry_t                  push_data
);

  logic [HASH_W-1:0]                     hash_a, hash_b, hash_c, hash_d;
  logic [WIDX_W-1:0]                     word_index;
  logic [SIZE_LOG_W-1:0]                 sl_eff;
  logic [IDX_W-1:0]                      mask;
  logic [NUM_PROBES_W-1:0]               k_eff;
  logic [NUM_PROBES_MAX-1:0][HASH_W-1:0] probe;
  logic                                  take;

  assign hash_a     = in_tdata[HASH_W-1:0];
  assign hash_b     = in_tdata[2*HASH_W-1:HASH_W];
  assign hash_c     = in_tdata[3*HASH_W-1:2*HASH_W];
  assign hash_d     = in_tdata[4*HASH_W-1:3*HASH_W];
  assign word_index = in_tdata[4*HASH_W+WIDX_W-1:4*HASH_W];

  assign in_tready = push_ready && !init_busy;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    priority if (size_log < SIZE_LOG_W'(SIZE_LOG_MIN)) begin
      sl_eff = SIZE_LOG_W'(SIZE_LOG_MIN);
    end else if (size_log > SIZE_LOG_W'(MAX_SIZE_LOG)) begin
      sl_eff = SIZE_LOG_W'(MAX_SIZE_LOG);
    end else begin
      sl_eff = size_log;
    end

    priority if (num_probes == '0) begin
      k_eff = NUM_PROBES_W'(1);
    end else if (num_probes > NUM_PROBES_W'(NUM_PROBES_MAX)) begin
      k_eff = NUM_PROBES_W'(NUM_PROBES_MAX);
    end else begin
      k_eff = num_probes;
    end
  end

  // a shift by the full index width leaves an all-ones mask
  assign mask = ~({IDX_W{1'b1}} << sl_eff);

  // probe order: b, a, c, d, then the same words rotated by half
  assign probe[0] = hash_b;
  assign probe[1] = hash_a;
  assign probe[2] = hash_c;
  assign probe[3] = hash_d;
  assign probe[4] = {hash_b[ROT_AMT-1:0], hash_b[HASH_W-1:ROT_AMT]};
  assign probe[5] = {hash_a[ROT_AMT-1:0], hash_a[HASH_W-1:ROT_AMT]};
  assign probe[6] = {hash_c[ROT_AMT-1:0], hash_c[HASH_W-1:ROT_AMT]};
  assign probe[7] = {hash_d[ROT_AMT-1:0], hash_d[HASH_W-1:ROT_AMT]};

  always_comb begin
    push_data            = '0;
    push_data.last_probe = PROBE_CW'(k_eff - NUM_PROBES_W'(1));
    for (int i = 0; i < NUM_PROBES_MAX; i++) begin
      push_data.idx[i] = probe[i][IDX_W-1:0] & mask;
    end
    push_data.word_index = WORD_AW'(word_index);
    // word beyond 2^(size_log-5) reads as zero
    push_data.rd_zero    = (word_index >> (sl_eff - SIZE_LOG_W'(SIZE_LOG_MIN))) != '0;
    push_valid           = 1'b0;
    unique case (in_tuser)
      KIND_INSERT: begin
        push_data.op = OP_INSERT;
        push_valid   = take;
      end
      KIND_READ: begin
        push_data.op = OP_READ;
        push_valid   = take;
      end
      KIND_CLEAR: begin
        push_data.op = OP_CLEAR;
        push_valid   = take;
      end
      default: begin
        push_data.op = OP_INSERT;   // unused kind is dropped
        push_valid   = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/bfi_queue.sv =====
// Short FIFO of classified entries between the front and back ends.
// Uses bfi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfi_queue
  import bfi_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push_valid,
  output      logic   push_ready,
  input  wire entry_t push_data,
  output      logic   pop_valid,
  input  wire logic   pop_ready,
  output      entry_t pop_data
);

  entry_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]     count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = count_r != (Q_AW+1)'(Q_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_ready && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? Q_AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? Q_AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bfi_back.sv =====
// Back end: sequencer that runs read-modify-write bit sets, word reads and
// clear sweeps on the bitmap RAM. Uses bfi_pkg and bfi_ram.
`timescale 1ns / 1ps
`default_nettype none

module bfi_back
  import bfi_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire entry_t            q_data,
  output      logic              q_pop,
  output      logic              init_busy,
  output      logic              out_tvalid,
  input  wire logic              out_tready,
  output      logic [WORD_W-1:0] out_tdata
);

  back_state_t        state_r, state_nxt;
  logic [WORD_AW-1:0] cnt_r, cnt_nxt;
  logic               init_r, init_nxt;
  entry_t             cur_r;

  logic               s2_ins_r, s2_rd_r, s2_zero_r;
  logic [WORD_AW-1:0] s2_addr_r;
  logic [BIT_W-1:0]   s2_bit_r;
  logic               fwd_r;
  logic [WORD_W-1:0]  fwd_data_r;
  logic               out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]  out_data_r, out_data_nxt;

  logic               can_take;
  logic               we, re;
  logic [WORD_AW-1:0] waddr, raddr;
  logic [WORD_W-1:0]  wdata, rdata, merged;
  logic [IDX_W-1:0]   cur_idx;

  bfi_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORD_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // a read issued in the same cycle as a write to that word sees the old word
  assign merged  = fwd_r ? fwd_data_r : rdata;
  assign cur_idx = cur_r.idx[cnt_r[PROBE_CW-1:0]];

  // a read may start only when its result has a free output register
  assign can_take = (q_data.op != OP_READ) || (!out_valid_r && !s2_rd_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (cnt_r == {WORD_AW{1'b1}}) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid && can_take) begin
          unique case (q_data.op)
            OP_INSERT: state_nxt = ST_INSERT;
            OP_READ:   state_nxt = ST_READ;
            OP_CLEAR:  state_nxt = ST_CLEAR;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_INSERT: begin
        if (cnt_r[PROBE_CW-1:0] == cur_r.last_probe) state_nxt = ST_IDLE;
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    q_pop    = 1'b0;
    re       = 1'b0;
    raddr    = '0;
    cnt_nxt  = cnt_r;
    init_nxt = init_r;
    unique case (state_r)
      ST_CLEAR: begin
        cnt_nxt = WORD_AW'(cnt_r + 1'b1);
        if (cnt_r == {WORD_AW{1'b1}}) init_nxt = 1'b0;
      end
      ST_IDLE: begin
        q_pop   = q_valid && can_take;
        cnt_nxt = '0;
      end
      ST_INSERT: begin
        re      = 1'b1;
        raddr   = cur_idx[IDX_W-1:BIT_W];
        cnt_nxt = WORD_AW'(cnt_r + 1'b1);
      end
      ST_READ: begin
        re    = 1'b1;
        raddr = cur_r.word_index;
      end
      default: ;
    endcase

    // the write port serves the bit-set stage, else the clear sweep
    if (s2_ins_r) begin
      we    = 1'b1;
      waddr = s2_addr_r;
      wdata = merged | (WORD_W'(1) << s2_bit_r);
    end else begin
      we    = state_r == ST_CLEAR;
      waddr = cnt_r;
      wdata = '0;
    end

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (s2_rd_r) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = s2_zero_r ? '0 : merged;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      init_r      <= 1'b1;
      s2_ins_r    <= 1'b0;
      s2_rd_r     <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      init_r      <= init_nxt;
      s2_ins_r    <= state_r == ST_INSERT;
      s2_rd_r     <= state_r == ST_READ;
      fwd_r       <= re && we && (waddr == raddr);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
    s2_addr_r  <= raddr;
    s2_bit_r   <= cur_idx[BIT_W-1:0];
    s2_zero_r  <= cur_r.rd_zero;
    fwd_data_r <= wdata;
    out_data_r <= out_data_nxt;
  end

  assign init_busy  = init_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== hdl/bloom_filter_bitmap_insert_core.sv =====
// Bloom filter bitmap insert core: config registers, front end, queue, back end.
// Read path: a read transaction passes the queue entry, the back end's ST_READ state, the
// RAM read data register and the output register before its word is on out_tdata. The back
// end is held by an insert for dispatch plus one RAM access per probe, by a read for dispatch
// and one RAM access (a read waits for a free output register), by a clear one word per cycle.
// Reset: synchronous, active low; then a sweep zeroes the bitmap, in_tready low.
`timescale 1ns / 1ps
`default_nettype none

module bloom_filter_bitmap_insert_core
  import bfi_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output      logic                  in_tready,
  // [31:0] hash_word_a, [63:32] hash_word_b, [95:64] hash_word_c,
  // [127:96] hash_word_d, [140:128] word_index, [143:141] zero
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  // [1:0] kind
  input  wire logic [1:0]            in_tuser,
  // result stream
  output      logic                  out_tvalid,
  input  wire logic                  out_tready,
  // [31:0] word_data
  output      logic [WORD_W-1:0]     out_tdata,
  // configuration port
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_AW-1:0]     cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output      logic [31:0]           cfg_prdata,
  output      logic                  cfg_pready
);

  logic [SIZE_LOG_W-1:0]   size_log_r, size_log_nxt;
  logic [NUM_PROBES_W-1:0] num_probes_r, num_probes_nxt;
  logic                    cfg_wr;

  logic   push_valid, push_ready;
  entry_t push_data;
  logic   pop_valid, pop_ready;
  entry_t pop_data;
  logic   init_busy;

  // ---------------------------------------------------------------------------
  // Configuration registers. Register select is paddr[2]; the low address
  // bits are don't-care. pready is tied high, so a write completes on the
  // access cycle.
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    size_log_nxt   = size_log_r;
    num_probes_nxt = num_probes_r;
    if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_SIZE_LOG:   size_log_nxt   = cfg_pwdata[SIZE_LOG_W-1:0];
        REG_NUM_PROBES: num_probes_nxt = cfg_pwdata[NUM_PROBES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_SIZE_LOG:   cfg_prdata = 32'(size_log_r);
      REG_NUM_PROBES: cfg_prdata = 32'(num_probes_r);
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_log_r   <= SIZE_LOG_W'(MAX_SIZE_LOG);
      num_probes_r <= NUM_PROBES_W'(2);
    end else begin
      size_log_r   <= size_log_nxt;
      num_probes_r <= num_probes_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Front end: classifies each transaction, clamps size and probe count,
  // masks the eight probe indices and range-checks reads. Unused kind is
  // accepted and dropped.
  // ---------------------------------------------------------------------------
  bfi_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (kind_t'(in_tuser)),
    .size_log   (size_log_r),
    .num_probes (num_probes_r),
    .init_busy  (init_busy),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  // Two-entry queue decouples intake from the RAM sequencer.
  bfi_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // ---------------------------------------------------------------------------
  // Back end: one RAM read per probe each cycle, the OR-in write in the cycle
  // after, with same-word forwarding between back-to-back probes. Reads land
  // in an output register so the queue keeps filling while a word waits.
  // ---------------------------------------------------------------------------
  bfi_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (pop_valid),
    .q_data     (pop_data),
    .q_pop      (pop_ready),
    .init_busy  (init_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
